### hdl/drop_pkg.sv
package drop_pkg;

  localparam int unsigned DNS_SLOTS         = 2;
  localparam int unsigned FRAME_LIMIT       = 1500;
  localparam int unsigned LINK_HEADER_BYTES = 42;

  localparam int unsigned WORDS      = 7;
  localparam int unsigned OFF_W      = 16;
  localparam int unsigned ADDR_W     = 4;
  localparam int unsigned DATA_W     = 64;

  localparam logic [OFF_W-1:0] OFFSET_CAP = {OFF_W{1'b1}};
  localparam logic [OFF_W-1:0] CODE_LIMIT = OFF_W'(FRAME_LIMIT - LINK_HEADER_BYTES);

  // Message byte offsets.
  localparam logic [OFF_W-1:0] OFF_XID_FIRST    = OFF_W'(4);
  localparam logic [OFF_W-1:0] OFF_XID_LAST     = OFF_W'(7);
  localparam logic [OFF_W-1:0] OFF_YIADDR_FIRST = OFF_W'(16);
  localparam logic [OFF_W-1:0] OFF_YIADDR_LAST  = OFF_W'(19);
  localparam logic [OFF_W-1:0] OFF_MAC_FIRST    = OFF_W'(28);
  localparam logic [OFF_W-1:0] OFF_MAC_LAST     = OFF_W'(33);
  localparam logic [OFF_W-1:0] OFF_COOKIE_FIRST = OFF_W'(236);
  localparam logic [OFF_W-1:0] OFF_COOKIE_LAST  = OFF_W'(239);
  localparam logic [OFF_W-1:0] OFF_OPTIONS      = OFF_W'(240);

  // Option codes.
  localparam logic [7:0] OPT_PAD    = 8'd0;
  localparam logic [7:0] OPT_SUBNET = 8'd1;
  localparam logic [7:0] OPT_ROUTER = 8'd3;
  localparam logic [7:0] OPT_DNS    = 8'd6;
  localparam logic [7:0] OPT_LEASE  = 8'd51;
  localparam logic [7:0] OPT_TYPE   = 8'd53;
  localparam logic [7:0] OPT_SERVER = 8'd54;
  localparam logic [7:0] OPT_END    = 8'd255;

  // Message types.
  localparam logic [2:0] TYPE_NONE  = 3'd0;
  localparam logic [2:0] TYPE_OFFER = 3'd2;
  localparam logic [2:0] TYPE_ACK   = 3'd5;

  // Lease word slots; slot zero is yiaddr and never an option target.
  localparam logic [2:0] SLOT_NONE   = 3'd0;
  localparam logic [2:0] SLOT_SERVER = 3'd1;
  localparam logic [2:0] SLOT_LEASE  = 3'd2;
  localparam logic [2:0] SLOT_SUBNET = 3'd3;
  localparam logic [2:0] SLOT_ROUTER = 3'd4;
  localparam logic [2:0] SLOT_DNS0   = 3'd5;

  // Register indexes.
  localparam logic REG_XID = 1'b0;
  localparam logic REG_MAC = 1'b1;

  typedef enum logic [1:0] {
    ST_REJECTED = 2'd0,
    ST_IGNORED  = 2'd1,
    ST_STORED   = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    PH_CODE  = 4'b0001,
    PH_LEN   = 4'b0010,
    PH_VALUE = 4'b0100,
    PH_DONE  = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [31:0] xid;
    logic [47:0] mac;
  } cfg_t;

  typedef struct packed {
    status_e     status;
    logic [2:0]  lease_type;
    logic [WORDS-1:0][31:0] words;
  } result_t;

  function automatic logic [2:0] slot_of(logic [7:0] code);
    logic [2:0] slot;
    case (code)
      OPT_SERVER: slot = SLOT_SERVER;
      OPT_LEASE:  slot = SLOT_LEASE;
      OPT_SUBNET: slot = SLOT_SUBNET;
      OPT_ROUTER: slot = SLOT_ROUTER;
      default:    slot = SLOT_NONE;
    endcase
    return slot;
  endfunction

  function automatic logic [7:0] cookie_byte(logic [1:0] idx);
    logic [7:0] val;
    case (idx)
      2'd0:    val = 8'd99;
      2'd1:    val = 8'd130;
      2'd2:    val = 8'd83;
      default: val = 8'd99;
    endcase
    return val;
  endfunction

endpackage

### hdl/drop_cfg_regs.sv
module drop_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [drop_pkg::ADDR_W-1:0]  paddr,
  input  logic [drop_pkg::DATA_W-1:0]  pwdata,
  output logic [drop_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output drop_pkg::cfg_t               cfg_o
);

  logic [31:0] xid_q;
  logic [47:0] mac_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // Registers sit on an 8-byte stride, so bit 3 selects the register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xid_q <= '0;
      mac_q <= '0;
    end else if (wr_en) begin
      if (paddr[3] == drop_pkg::REG_MAC) begin
        mac_q <= pwdata[47:0];
      end else begin
        xid_q <= pwdata[31:0];
      end
    end
  end

  always_comb begin
    if (paddr[3] == drop_pkg::REG_MAC) begin
      prdata = {16'b0, mac_q};
    end else begin
      prdata = {32'b0, xid_q};
    end
  end

  assign cfg_o.xid = xid_q;
  assign cfg_o.mac = mac_q;

endmodule

### hdl/drop_parser.sv
module drop_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  drop_pkg::cfg_t    cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              operation_i,
  input  logic [7:0]        data_byte_i,
  input  logic              last_i,
  input  logic              slot_free_i,
  output logic              res_valid_o,
  output drop_pkg::result_t res_o
);

  localparam int unsigned W = drop_pkg::WORDS;

  // Input register.
  logic       item_valid_q;
  logic       op_q;
  logic [7:0] byte_q;
  logic       last_q;
  logic       advance;

  // Per-message state.
  logic [drop_pkg::OFF_W-1:0] off_q, off_d;
  drop_pkg::phase_e           phase_q, phase_d;
  logic [7:0]                 code_q, code_d;
  logic [7:0]                 remain_q, remain_d;
  logic [7:0]                 idx_q, idx_d;
  logic [31:0]                acc_q, acc_d;
  logic                       mismatch_q, mismatch_d;
  logic                       ignore_q, ignore_d;
  logic                       magic_q, magic_d;
  logic [W-1:0][31:0]         cand_q, cand_d;
  logic [2:0]                 ctype_q, ctype_d;

  // Stored lease.
  logic [W-1:0][31:0]         stored_q, stored_d;
  logic [2:0]                 stype_q, stype_d;

  drop_pkg::status_e          status;

  assign advance    = item_valid_q & (op_q | ~last_q | slot_free_i);
  assign in_ready_o = ~item_valid_q | advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      op_q   <= operation_i;
      byte_q <= data_byte_i;
      last_q <= last_i;
    end
  end

  always_comb begin
    logic [2:0]  slot;
    logic [31:0] shifted;
    logic [31:0] base;
    logic [47:0] mac_sh;
    logic [31:0] xid_sh;
    logic [2:0]  mac_sel;

    off_d      = off_q;
    phase_d    = phase_q;
    code_d     = code_q;
    remain_d   = remain_q;
    idx_d      = idx_q;
    acc_d      = acc_q;
    mismatch_d = mismatch_q;
    ignore_d   = ignore_q;
    magic_d    = magic_q;
    cand_d     = cand_q;
    ctype_d    = ctype_q;
    stored_d   = stored_q;
    stype_d    = stype_q;
    status     = drop_pkg::ST_REJECTED;

    slot    = drop_pkg::slot_of(code_q);
    shifted = 32'(byte_q) << {~idx_q[1:0], 3'b000};
    xid_sh  = cfg_i.xid >> {~off_q[1:0], 3'b000};
    mac_sel = 3'(drop_pkg::OFF_MAC_LAST - off_q);
    mac_sh  = cfg_i.mac >> {mac_sel, 3'b000};
    base    = '0;

    if (op_q) begin
      stored_d = '0;
      stype_d  = drop_pkg::TYPE_NONE;
    end else begin
      if (off_q >= drop_pkg::OFF_XID_FIRST && off_q <= drop_pkg::OFF_XID_LAST) begin
        if (byte_q != xid_sh[7:0]) begin
          mismatch_d = 1'b1;
        end
      end else if (off_q >= drop_pkg::OFF_YIADDR_FIRST &&
                   off_q <= drop_pkg::OFF_YIADDR_LAST) begin
        cand_d[0] = cand_q[0] | (32'(byte_q) << {~off_q[1:0], 3'b000});
      end else if (off_q >= drop_pkg::OFF_MAC_FIRST && off_q <= drop_pkg::OFF_MAC_LAST) begin
        if (byte_q != mac_sh[7:0]) begin
          mismatch_d = 1'b1;
        end
      end else if (off_q >= drop_pkg::OFF_COOKIE_FIRST &&
                   off_q <= drop_pkg::OFF_COOKIE_LAST) begin
        if (byte_q != drop_pkg::cookie_byte(off_q[1:0])) begin
          magic_d = 1'b0;
        end
      end else if (off_q >= drop_pkg::OFF_OPTIONS && magic_q) begin
        case (phase_q)
          drop_pkg::PH_CODE: begin
            if (off_q >= drop_pkg::CODE_LIMIT || byte_q == drop_pkg::OPT_END) begin
              phase_d = drop_pkg::PH_DONE;
            end else if (byte_q != drop_pkg::OPT_PAD) begin
              code_d  = byte_q;
              phase_d = drop_pkg::PH_LEN;
            end
          end
          drop_pkg::PH_LEN: begin
            remain_d = byte_q;
            idx_d    = '0;
            acc_d    = '0;
            if (slot != drop_pkg::SLOT_NONE) begin
              cand_d[slot] = '0;
            end
            if (byte_q == 8'd0) begin
              if (code_q == drop_pkg::OPT_TYPE) begin
                ignore_d = 1'b1;
              end
              phase_d = drop_pkg::PH_CODE;
            end else begin
              phase_d = drop_pkg::PH_VALUE;
            end
          end
          drop_pkg::PH_VALUE: begin
            if (code_q == drop_pkg::OPT_TYPE) begin
              if (idx_q == 8'd0) begin
                if (byte_q == 8'(drop_pkg::TYPE_OFFER) && stype_q == drop_pkg::TYPE_ACK) begin
                  ignore_d = 1'b1;
                end else if (byte_q == 8'(drop_pkg::TYPE_OFFER) ||
                             byte_q == 8'(drop_pkg::TYPE_ACK)) begin
                  ctype_d = byte_q[2:0];
                end else begin
                  ignore_d = 1'b1;
                end
              end
            end else if (slot != drop_pkg::SLOT_NONE) begin
              if (idx_q < 8'd4) begin
                acc_d        = acc_q | shifted;
                cand_d[slot] = acc_q | shifted;
              end
            end else if (code_q == drop_pkg::OPT_DNS) begin
              // Each of the first two complete groups of four value bytes fills one server slot.
              base  = (idx_q[1:0] == 2'd0) ? 32'd0 : acc_q;
              acc_d = base | shifted;
              if (idx_q[1:0] == 2'd3 && idx_q[7:2] < 6'(drop_pkg::DNS_SLOTS)) begin
                cand_d[drop_pkg::SLOT_DNS0 + 3'(idx_q[2])] = base | shifted;
              end
            end
            idx_d    = idx_q + 8'd1;
            remain_d = remain_q - 8'd1;
            if (remain_q == 8'd1) begin
              phase_d = drop_pkg::PH_CODE;
            end
          end
          default: begin
          end
        endcase
      end

      if (off_q != drop_pkg::OFFSET_CAP) begin
        off_d = off_q + drop_pkg::OFF_W'(1);
      end

      if (last_q) begin
        if (mismatch_d || off_q < drop_pkg::OFF_MAC_LAST) begin
          status = drop_pkg::ST_REJECTED;
        end else if (ignore_d || ctype_d == drop_pkg::TYPE_NONE ||
                     (stype_q != drop_pkg::TYPE_NONE && cand_d[1] != stored_q[1])) begin
          status = drop_pkg::ST_IGNORED;
        end else begin
          stored_d = cand_d;
          stype_d  = ctype_d;
          status   = drop_pkg::ST_STORED;
        end
        // Start over for the next message.
        off_d      = '0;
        phase_d    = drop_pkg::PH_CODE;
        code_d     = '0;
        remain_d   = '0;
        idx_d      = '0;
        acc_d      = '0;
        mismatch_d = 1'b0;
        ignore_d   = 1'b0;
        magic_d    = 1'b1;
        cand_d     = '0;
        ctype_d    = drop_pkg::TYPE_NONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q      <= '0;
      phase_q    <= drop_pkg::PH_CODE;
      code_q     <= '0;
      remain_q   <= '0;
      idx_q      <= '0;
      acc_q      <= '0;
      mismatch_q <= 1'b0;
      ignore_q   <= 1'b0;
      magic_q    <= 1'b1;
      cand_q     <= '0;
      ctype_q    <= drop_pkg::TYPE_NONE;
      stored_q   <= '0;
      stype_q    <= drop_pkg::TYPE_NONE;
    end else if (advance) begin
      off_q      <= off_d;
      phase_q    <= phase_d;
      code_q     <= code_d;
      remain_q   <= remain_d;
      idx_q      <= idx_d;
      acc_q      <= acc_d;
      mismatch_q <= mismatch_d;
      ignore_q   <= ignore_d;
      magic_q    <= magic_d;
      cand_q     <= cand_d;
      ctype_q    <= ctype_d;
      stored_q   <= stored_d;
      stype_q    <= stype_d;
    end
  end

  assign res_valid_o      = advance & ~op_q & last_q;
  assign res_o.status     = status;
  assign res_o.lease_type = stype_d;
  assign res_o.words      = stored_d;

endmodule

### hdl/drop_result_reg.sv
module drop_result_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              res_valid_i,
  input  drop_pkg::result_t res_i,
  output logic              slot_free_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output drop_pkg::result_t res_o
);

  logic              valid_q;
  drop_pkg::result_t res_q;

  assign slot_free_o = ~valid_q | out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (slot_free_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_free_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

### hdl/dhcp_reply_option_parser_unit.sv
// Channel   Handshake                 Payload
// input     in_valid_i / in_ready_o   operation_i, data_byte_i, last_i
// result    out_valid_o / out_ready_i status_o, lease_type_o, seven lease words
// config    APB psel/penable/pwrite   paddr (xid at 0, mac at 8), pwdata, prdata
//
// One byte transaction is taken every cycle unless the input stalls; the per-byte
// state update is a single pass of logic between the input register and the state
// and result registers. A last byte is held in the input register, and its result
// is then captured in the result register. Reset is asynchronous and active low;
// no clearing pass follows it. Input stalls only when a last byte meets a full
// result register that is not being drained.
module dhcp_reply_option_parser_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [drop_pkg::ADDR_W-1:0]  paddr,
  input  logic [drop_pkg::DATA_W-1:0]  pwdata,
  output logic [drop_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         operation_i,
  input  logic [7:0]                   data_byte_i,
  input  logic                         last_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   status_o,
  output logic [2:0]                   lease_type_o,
  output logic [31:0]                  offered_ip_o,
  output logic [31:0]                  server_id_o,
  output logic [31:0]                  lease_seconds_o,
  output logic [31:0]                  subnet_mask_o,
  output logic [31:0]                  router_ip_o,
  output logic [31:0]                  dns_first_o,
  output logic [31:0]                  dns_second_o
);

  drop_pkg::cfg_t    cfg;
  drop_pkg::result_t res;
  drop_pkg::result_t res_out;
  logic              res_valid;
  logic              slot_free;

  drop_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  drop_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .data_byte_i (data_byte_i),
    .last_i      (last_i),
    .slot_free_i (slot_free),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  drop_result_reg u_result (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .slot_free_o (slot_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res_out)
  );

  assign status_o        = res_out.status;
  assign lease_type_o    = res_out.lease_type;
  assign offered_ip_o    = res_out.words[0];
  assign server_id_o     = res_out.words[1];
  assign lease_seconds_o = res_out.words[2];
  assign subnet_mask_o   = res_out.words[3];
  assign router_ip_o     = res_out.words[4];
  assign dns_first_o     = res_out.words[5];
  assign dns_second_o    = res_out.words[6];

endmodule

### bench/dhcp_reply_option_parser_unit_test.sv
module dhcp_reply_option_parser_unit_test;
  import drop_pkg::*;

  localparam int DRAIN_CYCLES = 6;
  localparam logic [ADDR_W-1:0] XID_ADDR = ADDR_W'(8 * REG_XID);
  localparam logic [ADDR_W-1:0] MAC_ADDR = ADDR_W'(8 * REG_MAC);
  localparam logic [31:0] COOKIE_WORD = {8'd99, 8'd130, 8'd83, 8'd99};

  logic clk_i = 1'b0;
  logic rst_ni;
  logic psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata, prdata;
  logic in_valid_i, in_ready_o, operation_i, last_i;
  logic [7:0] data_byte_i;
  logic out_valid_o, out_ready_i;
  logic [1:0] status_o;
  logic [2:0] lease_type_o;
  logic [31:0] offered_ip_o, server_id_o, lease_seconds_o, subnet_mask_o;
  logic [31:0] router_ip_o, dns_first_o, dns_second_o;

  dhcp_reply_option_parser_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .data_byte_i    (data_byte_i),
    .last_i         (last_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .lease_type_o   (lease_type_o),
    .offered_ip_o   (offered_ip_o),
    .server_id_o    (server_id_o),
    .lease_seconds_o(lease_seconds_o),
    .subnet_mask_o  (subnet_mask_o),
    .router_ip_o    (router_ip_o),
    .dns_first_o    (dns_first_o),
    .dns_second_o   (dns_second_o)
  );

  always #5 clk_i = ~clk_i;

  // Parser state mirrored by the lease predictor.
  logic [31:0] cfg_xid;
  logic [47:0] cfg_mac;
  logic [OFF_W-1:0] msg_offset;
  phase_e opt_phase;
  logic [7:0] opt_code, opt_left, opt_index;
  logic [31:0] opt_acc;
  logic id_mismatch, msg_ignored, cookie_good;
  logic [WORDS-1:0][31:0] cand_lease, kept_lease;
  logic [2:0] cand_type, kept_type;
  result_t lease_queue [$];

  logic [7:0] msg_buf [$];
  logic [31:0] server_pool [2];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int clear_per_mille = 0;
  int mismatch_count = 0;
  int bytes_sent = 0;
  int clears_sent = 0;
  int messages_sent = 0;
  int register_writes = 0;
  int status_tally [3] = '{0, 0, 0};

  function automatic bit chance(input int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic int word_target(input logic [7:0] code);
    case (code)
      OPT_SERVER: return SLOT_SERVER;
      OPT_LEASE:  return SLOT_LEASE;
      OPT_SUBNET: return SLOT_SUBNET;
      OPT_ROUTER: return SLOT_ROUTER;
      default:    return -1;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("MISMATCH at %0t: %s got %0h expected %0h", $time, what, got, want);
  endtask

  task automatic restart_message();
    msg_offset = '0;
    opt_phase = PH_CODE;
    opt_code = '0;
    opt_left = '0;
    opt_index = '0;
    opt_acc = '0;
    id_mismatch = 1'b0;
    msg_ignored = 1'b0;
    cookie_good = 1'b1;
    cand_lease = '0;
    cand_type = TYPE_NONE;
  endtask

  task automatic take_value_byte(input logic [7:0] b);
    int target, k, grp, sub;
    target = word_target(opt_code);
    k = int'(opt_index);
    if (opt_code == OPT_TYPE) begin
      if (k == 0) begin
        if (b == TYPE_OFFER && kept_type == TYPE_ACK) msg_ignored = 1'b1;
        else if (b == TYPE_OFFER || b == TYPE_ACK) cand_type = b[2:0];
        else msg_ignored = 1'b1;
      end
    end else if (target >= 0) begin
      if (k < 4) begin
        opt_acc |= 32'(b) << (24 - 8 * k);
        cand_lease[target] = opt_acc;
      end
    end else if (opt_code == OPT_DNS) begin
      // Name servers fill only from complete groups of four bytes.
      grp = k / 4;
      sub = k % 4;
      if (sub == 0) opt_acc = '0;
      opt_acc |= 32'(b) << (24 - 8 * sub);
      if (sub == 3 && grp < DNS_SLOTS && grp < 2) cand_lease[SLOT_DNS0 + grp] = opt_acc;
    end
  endtask

  task automatic parse_option_byte(input int pos, input logic [7:0] b);
    case (opt_phase)
      PH_CODE: begin
        if (pos + LINK_HEADER_BYTES >= FRAME_LIMIT || b == OPT_END) begin
          opt_phase = PH_DONE;
        end else if (b != OPT_PAD) begin
          opt_code = b;
          opt_phase = PH_LEN;
        end
      end
      PH_LEN: begin
        opt_left = b;
        opt_index = '0;
        opt_acc = '0;
        if (word_target(opt_code) >= 0) cand_lease[word_target(opt_code)] = '0;
        if (b == 8'd0) begin
          if (opt_code == OPT_TYPE) msg_ignored = 1'b1;
          opt_phase = PH_CODE;
        end else begin
          opt_phase = PH_VALUE;
        end
      end
      PH_VALUE: begin
        take_value_byte(b);
        opt_index = opt_index + 8'd1;
        opt_left = opt_left - 8'd1;
        if (opt_left == 8'd0) opt_phase = PH_CODE;
      end
      default: ;
    endcase
  endtask

  task automatic predict_lease(input logic op, input logic [7:0] b, input logic lst);
    int pos;
    result_t want;
    if (op) begin
      kept_lease = '0;
      kept_type = TYPE_NONE;
      clears_sent++;
      return;
    end
    bytes_sent++;
    pos = int'(msg_offset);
    if (pos >= 4 && pos <= 7) begin
      if (b != cfg_xid[8 * (7 - pos) +: 8]) id_mismatch = 1'b1;
    end else if (pos >= 16 && pos <= 19) begin
      cand_lease[0] |= 32'(b) << (8 * (19 - pos));
    end else if (pos >= 28 && pos <= 33) begin
      if (b != cfg_mac[8 * (33 - pos) +: 8]) id_mismatch = 1'b1;
    end else if (pos >= 236 && pos <= 239) begin
      if (b != COOKIE_WORD[8 * (239 - pos) +: 8]) cookie_good = 1'b0;
    end else if (pos >= 240 && cookie_good) begin
      parse_option_byte(pos, b);
    end
    if (msg_offset < OFFSET_CAP) msg_offset = msg_offset + OFF_W'(1);
    if (!lst) return;

    if (id_mismatch || pos < 33) begin
      want.status = ST_REJECTED;
    end else if (msg_ignored || cand_type == TYPE_NONE ||
                 (kept_type != TYPE_NONE && cand_lease[SLOT_SERVER] != kept_lease[SLOT_SERVER])) begin
      want.status = ST_IGNORED;
    end else begin
      kept_lease = cand_lease;
      kept_type = cand_type;
      want.status = ST_STORED;
    end
    want.lease_type = kept_type;
    want.words = kept_lease;
    lease_queue.push_back(want);
    status_tally[int'(want.status)]++;
    restart_message();
  endtask

  // Each accepted result is checked against the oldest predicted lease report.
  always @(posedge clk_i) begin : check_results
    result_t want;
    logic [WORDS-1:0][31:0] got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {dns_second_o, dns_first_o, router_ip_o, subnet_mask_o,
             lease_seconds_o, server_id_o, offered_ip_o};
      if (lease_queue.size() == 0) begin
        report_mismatch("result with no reply pending", status_o, 0);
      end else begin
        want = lease_queue.pop_front();
        if (status_o !== want.status) report_mismatch("status", status_o, want.status);
        if (lease_type_o !== want.lease_type)
          report_mismatch("lease type", lease_type_o, want.lease_type);
        for (int w = 0; w < WORDS; w++)
          if (got[w] !== want.words[w])
            report_mismatch($sformatf("lease word %0d", w), got[w], want.words[w]);
      end
    end
  end

  always @(negedge clk_i) out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);

  task automatic send_item(input logic op, input logic [7:0] b, input logic lst);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    data_byte_i <= b;
    last_i <= lst;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_lease(op, b, lst);
    @(negedge clk_i);
  endtask

  task automatic ship_message();
    foreach (msg_buf[i]) begin
      if (clear_per_mille > 0 && $urandom_range(0, 999) < clear_per_mille)
        send_item(1'b1, 8'($urandom), 1'($urandom));
      send_item(1'b0, msg_buf[i], i == msg_buf.size() - 1);
    end
    messages_sent++;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (lease_queue.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_register(input logic reg_sel, input logic [63:0] value);
    logic [63:0] mask, stored;
    settle();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= (reg_sel == REG_MAC) ? MAC_ADDR : XID_ADDR;
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (reg_sel == REG_MAC) cfg_mac = value[47:0];
    else cfg_xid = value[31:0];
    register_writes++;
    @(negedge clk_i);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    mask = (reg_sel == REG_MAC) ? 64'hFFFF_FFFF_FFFF : 64'hFFFF_FFFF;
    stored = (reg_sel == REG_MAC) ? 64'(cfg_mac) : 64'(cfg_xid);
    if ((prdata & mask) !== stored) report_mismatch("register read-back", prdata & mask, stored);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Fixed BOOTP header up to and including the magic cookie.
  task automatic begin_reply(input logic [31:0] xid, input logic [47:0] mac,
                             input logic [31:0] yiaddr, input logic cookie_ok);
    logic [7:0] b;
    int bad;
    msg_buf.delete();
    bad = cookie_ok ? -1 : int'($urandom_range(0, 3));
    for (int i = 0; i < 240; i++) begin
      b = 8'($urandom);
      if (i == 0) b = 8'd2;
      else if (i >= 4 && i <= 7) b = xid[8 * (7 - i) +: 8];
      else if (i >= 16 && i <= 19) b = yiaddr[8 * (19 - i) +: 8];
      else if (i >= 28 && i <= 33) b = mac[8 * (33 - i) +: 8];
      else if (i >= 236)
        b = COOKIE_WORD[8 * (239 - i) +: 8] ^ ((i - 236 == bad) ? 8'($urandom_range(1, 255)) : 8'd0);
      msg_buf.push_back(b);
    end
  endtask

  task automatic put_option(input logic [7:0] code, input int len, input logic [31:0] lead);
    msg_buf.push_back(code);
    msg_buf.push_back(8'(len));
    for (int k = 0; k < len; k++) msg_buf.push_back(k < 4 ? lead[8 * (3 - k) +: 8] : 8'($urandom));
  endtask

  task automatic pad_to(input int size);
    while (msg_buf.size() < size) msg_buf.push_back(OPT_PAD);
  endtask

  task automatic cut_message(input int size);
    while (msg_buf.size() > size) void'(msg_buf.pop_back());
  endtask

  task automatic full_reply(input logic [7:0] kind, input logic [31:0] server);
    begin_reply(cfg_xid, cfg_mac, $urandom, 1'b1);
    put_option(OPT_TYPE, 1, {kind, 24'h0});
    put_option(OPT_SERVER, 4, server);
    put_option(OPT_LEASE, 4, $urandom);
    put_option(OPT_SUBNET, 4, $urandom);
    put_option(OPT_ROUTER, 4, $urandom);
    put_option(OPT_DNS, 8, $urandom);
    msg_buf.push_back(OPT_END);
  endtask

  function automatic int word_len();
    return chance(70) ? 4 : int'($urandom_range(0, 8));
  endfunction

  function automatic int dns_len();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return 4;
    if (r < 7) return 8;
    return $urandom_range(0, 13);
  endfunction

  function automatic logic [31:0] pick_server();
    if (chance(10)) return $urandom;
    return server_pool[chance(80) ? 0 : 1];
  endfunction

  task automatic put_type_option();
    int len, r;
    logic [7:0] kind;
    len = chance(90) ? 1 : (chance(50) ? 0 : int'($urandom_range(2, 3)));
    r = $urandom_range(0, 99);
    kind = (r < 45) ? 8'(TYPE_OFFER) : (r < 85) ? 8'(TYPE_ACK) : 8'($urandom);
    put_option(OPT_TYPE, len, {kind, 24'($urandom)});
  endtask

  // Mostly well-formed replies with random content; some are damaged or cut short.
  task automatic random_reply();
    logic [31:0] xid;
    logic [47:0] mac;
    xid = chance(92) ? cfg_xid : cfg_xid ^ (32'd1 << $urandom_range(0, 31));
    mac = chance(92) ? cfg_mac : cfg_mac ^ (48'd1 << $urandom_range(0, 47));
    begin_reply(xid, mac, $urandom, chance(95));
    if (chance(85)) put_type_option();
    if (chance(80)) put_option(OPT_SERVER, word_len(), pick_server());
    repeat ($urandom_range(0, 7)) begin
      case ($urandom_range(0, 9))
        0: put_type_option();
        1: put_option(OPT_SERVER, word_len(), pick_server());
        2: put_option(OPT_LEASE, word_len(), $urandom);
        3: put_option(OPT_SUBNET, word_len(), $urandom);
        4: put_option(OPT_ROUTER, word_len(), $urandom);
        5, 6: put_option(OPT_DNS, dns_len(), $urandom);
        7: repeat ($urandom_range(1, 3)) msg_buf.push_back(OPT_PAD);
        8: put_option(8'($urandom_range(1, 254)), $urandom_range(0, 10), $urandom);
        default: begin
          if (chance(8)) pad_to($urandom_range(1440, 1470));
          else put_option(8'($urandom_range(1, 254)), $urandom_range(0, 10), $urandom);
        end
      endcase
    end
    if (chance(85)) msg_buf.push_back(OPT_END);
    repeat ($urandom_range(0, 6)) msg_buf.push_back(8'($urandom));
    if (chance(15)) cut_message($urandom_range(1, msg_buf.size()));
  endtask

  task automatic test_lease_sequence();
    full_reply(8'(TYPE_OFFER), server_pool[0]);
    ship_message();
    full_reply(8'(TYPE_ACK), server_pool[0]);
    ship_message();
    full_reply(8'(TYPE_OFFER), server_pool[0]);
    ship_message();
    full_reply(8'(TYPE_ACK), server_pool[1]);
    ship_message();
    // A clear transaction ignores its data and last flag.
    send_item(1'b1, 8'hFF, 1'b1);
    full_reply(8'(TYPE_OFFER), server_pool[1]);
    ship_message();
  endtask

  task automatic test_identity_checks();
    write_register(REG_XID, 64'hFFFF_FFFF);
    write_register(REG_MAC, 64'hFFFF_FFFF_FFFF);
    full_reply(8'(TYPE_ACK), server_pool[1]);
    ship_message();
    begin_reply(cfg_xid ^ 32'h1, cfg_mac, $urandom, 1'b1);
    put_option(OPT_TYPE, 1, {8'(TYPE_ACK), 24'h0});
    msg_buf.push_back(OPT_END);
    ship_message();
    begin_reply(cfg_xid, cfg_mac ^ 48'h8000_0000_0000, $urandom, 1'b1);
    put_option(OPT_TYPE, 1, {8'(TYPE_ACK), 24'h0});
    ship_message();
    // Messages ending just before, at and past the last address byte.
    for (int n = 33; n <= 35; n++) begin
      begin_reply(cfg_xid, cfg_mac, $urandom, 1'b1);
      cut_message(n);
      ship_message();
    end
    begin_reply(cfg_xid, cfg_mac, $urandom, 1'b1);
    cut_message(20);
    ship_message();
    send_item(1'b0, 8'h00, 1'b1);
  endtask

  task automatic test_option_corners();
    full_reply(8'(TYPE_ACK), server_pool[1]);
    msg_buf[237] = 8'h00;
    ship_message();
    begin_reply(cfg_xid, cfg_mac, $urandom, 1'b1);
    put_option(OPT_TYPE, 0, 32'h0);
    put_option(OPT_SERVER, 4, server_pool[1]);
    ship_message();
    // An unknown type stays ignored even when a valid type follows.
    begin_reply(cfg_xid, cfg_mac, $urandom, 1'b1);
    put_option(OPT_TYPE, 1, 32'h0700_0000);
    put_option(OPT_TYPE, 1, {8'(TYPE_ACK), 24'h0});
    put_option(OPT_SERVER, 4, server_pool[1]);
    ship_message();
    begin_reply(cfg_xid, cfg_mac, $urandom, 1'b1);
    put_option(OPT_TYPE, 1, {8'(TYPE_ACK), 24'h0});
    put_option(OPT_SERVER, 4, server_pool[1]);
    put_option(OPT_LEASE, 2, $urandom);
    put_option(OPT_SUBNET, 6, $urandom);
    put_option(OPT_ROUTER, 0, 32'h0);
    msg_buf.push_back(OPT_PAD);
    msg_buf.push_back(OPT_PAD);
    put_option(OPT_DNS, 11, $urandom);
    msg_buf.push_back(OPT_END);
    put_option(OPT_TYPE, 1, {8'(TYPE_OFFER), 24'h0});
    ship_message();
    begin_reply(cfg_xid, cfg_mac, $urandom, 1'b1);
    put_option(OPT_TYPE, 1, {8'(TYPE_ACK), 24'h0});
    put_option(OPT_SERVER, 4, server_pool[1]);
    put_option(OPT_DNS, 12, $urandom);
    put_option(8'd200, 3, $urandom);
    put_option(OPT_ROUTER, 4, $urandom);
    put_option(OPT_DNS, 4, $urandom);
    msg_buf.push_back(OPT_END);
    ship_message();
  endtask

  task automatic test_frame_limit();
    // The next code byte after the server option sits exactly at the frame limit.
    begin_reply(cfg_xid, cfg_mac, $urandom, 1'b1);
    put_option(OPT_TYPE, 1, {8'(TYPE_ACK), 24'h0});
    pad_to(FRAME_LIMIT - LINK_HEADER_BYTES - 6);
    put_option(OPT_SERVER, 4, server_pool[1]);
    put_option(OPT_LEASE, 4, $urandom);
    msg_buf.push_back(OPT_END);
    ship_message();
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input logic [31:0] xid, input logic [47:0] mac);
    int first_msg, first_byte;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    write_register(REG_XID, 64'(xid));
    write_register(REG_MAC, 64'(mac));
    server_pool[0] = $urandom;
    server_pool[1] = $urandom;
    clear_per_mille = 3;
    first_msg = messages_sent;
    first_byte = bytes_sent;
    while (messages_sent - first_msg < 4 || bytes_sent - first_byte < 360) begin
      case ($urandom_range(0, 9))
        0: begin
          msg_buf.delete();
          repeat ($urandom_range(1, 60)) msg_buf.push_back(8'($urandom));
          ship_message();
        end
        1: repeat ($urandom_range(1, 3)) send_item(1'b1, 8'($urandom), 1'($urandom));
        default: begin
          random_reply();
          ship_message();
        end
      endcase
    end
    clear_per_mille = 0;
    settle();
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid_i = 1'b0;
    operation_i = 1'b0;
    data_byte_i = '0;
    last_i = 1'b0;
    out_ready_i = 1'b0;
    cfg_xid = '0;
    cfg_mac = '0;
    kept_lease = '0;
    kept_type = TYPE_NONE;
    restart_message();
    server_pool[0] = $urandom;
    server_pool[1] = $urandom;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_lease_sequence();
    test_identity_checks();
    test_option_corners();
    test_frame_limit();
    test_random_traffic(0, 0, $urandom, 48'({$urandom, $urandom}));
    test_random_traffic(55, 0, 32'hFFFF_FFFF, 48'h0);
    test_random_traffic(0, 55, 32'h0, 48'hFFFF_FFFF_FFFF);
    test_random_traffic(36, 36, $urandom, 48'({$urandom, $urandom}));

    in_valid_i <= 1'b0;
    for (int n = 0; n < 2000 && lease_queue.size() != 0; n++) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (lease_queue.size() != 0) report_mismatch("replies never answered", lease_queue.size(), 0);
    $display("Covered %0d replies: %0d stored, %0d ignored, %0d rejected, from %0d bytes.",
             messages_sent, status_tally[ST_STORED], status_tally[ST_IGNORED],
             status_tally[ST_REJECTED], bytes_sent);
    $display("Also %0d clear transactions and %0d register writes under four stall mixes.",
             clears_sent, register_writes);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timed out waiting on the parser.");
    $display("Regression FAIL");
    $finish;
  end

endmodule

### files.f
hdl/drop_pkg.sv
hdl/drop_cfg_regs.sv
hdl/drop_parser.sv
hdl/drop_result_reg.sv
hdl/dhcp_reply_option_parser_unit.sv
bench/dhcp_reply_option_parser_unit_test.sv
